FILE: hdl/aes128_single_round_defines.svh
// assertion macros for the aes128 single round block
`ifndef AES128_SINGLE_ROUND_DEFINES_SVH
`define AES128_SINGLE_ROUND_DEFINES_SVH
`ifndef SYNTHESIS
`define AES_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define AES_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define AES_ASSERT(label, clk, rst_n, prop)
`define AES_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hdl/aes_pkg.sv
// types, tables and byte functions for the aes128 single round block
package aes_pkg;
	typedef struct packed {
		logic [63:0] state_hi;
		logic [63:0] state_lo;
		logic [63:0] key0_hi;
		logic [63:0] key0_lo;
		logic [63:0] key1_hi;
		logic [63:0] key1_lo;
		logic        key_mode;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
		logic [63:0] next_key_hi;
		logic [63:0] next_key_lo;
	} out_beat_t;

	localparam logic KEY_MODE_DERIVE = 1'b0;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [16] = '{
	8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
	8'h80,8'h1b,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00
	};

	// byte i of a 128-bit word, byte 0 in the top bits
	function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
		return w[127 - 8*i -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction
endpackage

FILE: hdl/aes_mix.sv
// mixcolumns over all four columns of a 128-bit state
module aes_mix (
	input  logic [127:0] din,
	output logic [127:0] dout
);
	// each column mixes on its own
	always_comb begin
		logic [7:0] a0, a1, a2, a3, all;
		dout = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = aes_pkg::byte_of(din, 4*c);
			a1 = aes_pkg::byte_of(din, 4*c+1);
			a2 = aes_pkg::byte_of(din, 4*c+2);
			a3 = aes_pkg::byte_of(din, 4*c+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			dout[127 - 32*c -: 8]      = a0 ^ all ^ aes_pkg::xtime(a0 ^ a1);
			dout[127 - 32*c - 8 -: 8]  = a1 ^ all ^ aes_pkg::xtime(a1 ^ a2);
			dout[127 - 32*c - 16 -: 8] = a2 ^ all ^ aes_pkg::xtime(a2 ^ a3);
			dout[127 - 32*c - 24 -: 8] = a3 ^ all ^ aes_pkg::xtime(a3 ^ a0);
		end
	end
endmodule

FILE: hdl/aes128_single_round.sv
// top level: one aes-128 round with optional key-schedule step, three stages
// Three-stage pipeline: a beat enters every cycle while the output is not stalled
// (stage 1 initial key add and key-schedule s-box, stage 2 subbytes with shiftrows
// and key expansion, stage 3 mixcolumns and final key add). The whole pipeline
// advances together, holding when the output is stalled, so throughput is one
// beat per cycle. round_q (reset 1) picks the round constant; values outside
// 1 to 10 give a constant of zero.
`include "aes128_single_round_defines.svh"
module aes128_single_round (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  aes_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output aes_pkg::out_beat_t out_data
);
	logic [3:0] round_q;
	logic       v_s1, v_s2, v_s3;
	logic       adv;
	logic [127:0] st_s1, k0_s1, k1_s1;
	logic [31:0]  g_s1;
	logic         mode_s1;
	logic [127:0] st_s2, k1_s2;
	logic [127:0] st_s3, k1_s3;
	logic [127:0] st_in, k0_in, k1_in, sb, nk, mixed;
	logic [31:0]  g_in;

	// stage 3 empty or draining frees the whole line
	assign adv      = !v_s3 || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= 4'd1;
		end else if (cfg_we) begin
			round_q <= cfg_wdata;
		end
	end

	// stage 1 inputs: initial key add and g() of the last key word
	assign st_in = {in_data.state_hi, in_data.state_lo};
	assign k0_in = {in_data.key0_hi, in_data.key0_lo};
	assign k1_in = {in_data.key1_hi, in_data.key1_lo};
	assign g_in  = {aes_pkg::SBOX[aes_pkg::byte_of(k0_in, 13)] ^ aes_pkg::RCON[round_q],
		aes_pkg::SBOX[aes_pkg::byte_of(k0_in, 14)],
		aes_pkg::SBOX[aes_pkg::byte_of(k0_in, 15)],
		aes_pkg::SBOX[aes_pkg::byte_of(k0_in, 12)]};

	// stage 2 inputs: subbytes with shiftrows, and key expansion
	always_comb begin
		sb = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sb[127 - 8*(4*c+r) -: 8] =
					aes_pkg::SBOX[aes_pkg::byte_of(st_s1, 4*((c+r)%4)+r)];
			end
		end
		nk[127:96] = k0_s1[127:96] ^ g_s1;
		nk[95:64]  = k0_s1[95:64] ^ nk[127:96];
		nk[63:32]  = k0_s1[63:32] ^ nk[95:64];
		nk[31:0]   = k0_s1[31:0] ^ nk[63:32];
	end

	aes_mix u_mix (
		.din (st_s2),
		.dout(mixed)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1   <= st_in ^ k0_in;
			k0_s1   <= k0_in;
			k1_s1   <= k1_in;
			g_s1    <= g_in;
			mode_s1 <= in_data.key_mode;
			st_s2   <= sb;
			k1_s2   <= (mode_s1 == aes_pkg::KEY_MODE_DERIVE) ? nk : k1_s1;
			st_s3   <= mixed ^ k1_s2;
			k1_s3   <= k1_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = '{result_hi: st_s3[127:64], result_lo: st_s3[63:0],
		next_key_hi: k1_s3[127:64], next_key_lo: k1_s3[63:0]};

	`AES_ASSERT(a_stall_holds, clk, arst_n, (v_s3 && out_stall) |=> (v_s3 && $stable(k1_s3)))
	`AES_ASSERT_NEXT(a_fill, clk, arst_n, (in_valid && !in_stall), v_s1)
	`AES_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (v_s3 && out_stall))
endmodule

FILE: verif/tb.sv
// self-checking testbench for the aes128 single round block
module tb;
	localparam int LATENCY = 3;
	localparam int CYCLE_LIMIT = 400000;

	// expected round results in acceptance order
	class round_scoreboard;
		aes_pkg::out_beat_t pending[$];
		logic [3:0] round_num;
		int mismatches;

		function new();
			round_num = 4'd1;
			mismatches = 0;
		endfunction

		// one key-schedule step on a 128-bit key
		function logic [127:0] next_subkey(logic [127:0] k);
			logic [7:0] kb[16];
			logic [7:0] nk[16];
			logic [7:0] g[4];
			logic [127:0] r;
			for (int i = 0; i < 16; i++) kb[i] = k[127 - 8*i -: 8];
			g[0] = aes_pkg::SBOX[kb[13]] ^ aes_pkg::RCON[round_num];
			g[1] = aes_pkg::SBOX[kb[14]];
			g[2] = aes_pkg::SBOX[kb[15]];
			g[3] = aes_pkg::SBOX[kb[12]];
			for (int i = 0; i < 4; i++) nk[i] = kb[i] ^ g[i];
			for (int i = 4; i < 16; i++) nk[i] = kb[i] ^ nk[i-4];
			for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = nk[i];
			return r;
		endfunction

		function logic [7:0] dbl(logic [7:0] a);
			return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		endfunction

		// note an accepted input beat
		function void note_input(aes_pkg::in_beat_t b);
			logic [127:0] st, k0, k1;
			logic [7:0] s[16];
			logic [7:0] t[16];
			logic [7:0] a0, a1, a2, a3, al;
			aes_pkg::out_beat_t e;
			k0 = {b.key0_hi, b.key0_lo};
			k1 = (b.key_mode == aes_pkg::KEY_MODE_DERIVE) ? next_subkey(k0) :
				{b.key1_hi, b.key1_lo};
			st = {b.state_hi, b.state_lo} ^ k0;
			for (int i = 0; i < 16; i++) s[i] = st[127 - 8*i -: 8];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[4*c + r] = aes_pkg::SBOX[s[4*((c + r) & 3) + r]];
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				s[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
				s[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
				s[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
				s[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
			end
			for (int i = 0; i < 16; i++) st[127 - 8*i -: 8] = s[i];
			st = st ^ k1;
			e.result_hi = st[127:64];
			e.result_lo = st[63:0];
			e.next_key_hi = k1[127:64];
			e.next_key_lo = k1[63:0];
			pending.push_back(e);
		endfunction

		// compare an accepted output beat with the oldest expectation
		function void check_result(aes_pkg::out_beat_t got);
			aes_pkg::out_beat_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
				return;
			end
			e = pending.pop_front();
			if (got.result_hi !== e.result_hi || got.result_lo !== e.result_lo ||
			    got.next_key_hi !== e.next_key_hi || got.next_key_lo !== e.next_key_lo) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h_%h key %h_%h, got %h_%h key %h_%h",
						e.result_hi, e.result_lo, e.next_key_hi, e.next_key_lo,
						got.result_hi, got.result_lo, got.next_key_hi, got.next_key_lo);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [3:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	aes_pkg::in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	aes_pkg::out_beat_t out_data;

	round_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int cycles;

	aes128_single_round dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// check output beats and drive random stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_result(out_data);
			if (in_valid && !in_stall) sb.note_input(in_data);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random field with occasional extremes
	function logic [63:0] pick64();
		case ($urandom_range(9))
			0: return 64'h0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	// send one beat and hold it until accepted
	task send_beat(aes_pkg::in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task send_fields(logic [63:0] sh, logic [63:0] sl, logic [63:0] ah, logic [63:0] al,
			logic [63:0] bh, logic [63:0] bl, logic m);
		aes_pkg::in_beat_t b;
		b.state_hi = sh; b.state_lo = sl;
		b.key0_hi = ah; b.key0_lo = al;
		b.key1_hi = bh; b.key1_lo = bl;
		b.key_mode = m;
		send_beat(b);
	endtask

	task send_random();
		send_fields(pick64(), pick64(), pick64(), pick64(), pick64(), pick64(),
			1'($urandom_range(1)));
	endtask

	task wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// register write while idle
	task write_round(logic [3:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.round_num = v;
		@(posedge clk);
	endtask

	initial begin
		logic [3:0] rounds[6];
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, both key modes, fips-197 style vector
		send_fields('0, '0, '0, '0, '0, '0, 1'b0);
		send_fields('1, '1, '1, '1, '1, '1, 1'b0);
		send_fields('1, '1, '1, '1, '1, '1, 1'b1);
		send_fields('0, '0, '0, '0, '0, '0, 1'b1);
		send_fields(64'h3243f6a8885a308d, 64'h313198a2e0370734,
			64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '0, '0, 1'b0);
		send_fields(64'h0011223344556677, 64'h8899aabbccddeeff,
			64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'hd6aa74fdd2af72fa, 64'hdaa678f1d6ab76fe, 1'b1);
		send_fields(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
			64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, '1, '0, 1'b0);
		wait_drained();

		// round constants including out of range values
		rounds = '{4'd10, 4'd0, 4'd15, 4'd11, 4'd5, 4'd1};
		for (int p = 0; p < 6; p++) begin
			write_round(rounds[p]);
			send_fields('0, '0, '0, '0, '0, '0, 1'b0);
			send_fields('1, '1, '1, '1, '1, '1, 1'b0);
			wait_drained();
		end

		// random phases with different idling
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 51; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 51; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			write_round(4'($urandom_range(15)));
			for (int i = 0; i < 300; i++) begin
				send_random();
				if (i == 150) wait_drained();
			end
			wait_drained();
		end
		stall_pct = 0;
		wait_drained();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/aes_pkg.sv
hdl/aes_mix.sv
hdl/aes128_single_round.sv
verif/tb.sv
